FILE: src/pic_pkg.sv
// Package for the platform interrupt controller core.
// Holds address map constants and the beat payload structs; no dependencies.
package pic_pkg;

  localparam int MAX_IRQ   = 31;
  localparam int NUM_HARTS = 2;
  localparam int CTX_COUNT = 2 * NUM_HARTS;
  localparam int CTX_W     = $clog2(CTX_COUNT);
  localparam int SRC_W     = 5;

  localparam logic [23:0] PRIORITY_BASE    = 24'd0;
  localparam logic [23:0] ENABLE_BASE      = 24'd8192;
  localparam logic [23:0] THRESHOLD_BASE   = 24'd2097152;
  localparam logic [23:0] ENABLE_STRIDE    = 24'h000080;
  localparam logic [23:0] THRESHOLD_STRIDE = 24'h001000;

  localparam logic [23:0] PRIORITY_END  = PRIORITY_BASE + 24'((MAX_IRQ + 1) * 4);
  localparam logic [23:0] ENABLE_END    = ENABLE_BASE + 24'(CTX_COUNT) * ENABLE_STRIDE;
  localparam logic [23:0] THRESHOLD_END = THRESHOLD_BASE + 24'(CTX_COUNT) * THRESHOLD_STRIDE;

  localparam int ENABLE_SHIFT    = 7;   // log2 of the enable stride
  localparam int THRESHOLD_SHIFT = 12;  // log2 of the threshold stride

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [23:0] address;
    logic [7:0]  write_data;
    logic [31:0] irq_lines;
  } pic_in_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic             addr_error;
    logic             ack_valid;
    logic [SRC_W-1:0] ack_source;
  } pic_out_t;

endpackage

FILE: src/platform_interrupt_controller_core.sv
// Platform interrupt controller core: byte register interface, claim scan, ack.
// Depends on pic_pkg for the address map constants and beat structs.
//
//   channel | signals                          | beat
//   --------+----------------------------------+---------------------------------
//   input   | in_valid, in_ready, in_data      | cmd, address, write_data, lines
//   result  | out_valid, out_ready, out_data   | read_data, addr_error, ack
//
// One beat in, one beat out, through an input register, then the decode / byte merge /
// claim scan, then the result register. A new beat can be taken every cycle while
// in_ready is high; the 31-way priority compare and encoder sets the clock.
// Reset (rst_n low, synchronous) empties both stages and zeroes every store.
// A stalled result holds the result register; the input register keeps
// filling until both stages are full, then in_ready drops.

module platform_interrupt_controller_core
  import pic_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pic_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pic_out_t out_data
);

  // Replace one byte lane of a 32-bit word.
  function automatic logic [31:0] merge_byte(input logic [31:0] word,
                                             input logic [1:0]  lane,
                                             input logic [7:0]  data);
    logic [31:0] res;
    res = word;
    case (lane)
      2'd0:    res[7:0]   = data;
      2'd1:    res[15:8]  = data;
      2'd2:    res[23:16] = data;
      2'd3:    res[31:24] = data;
      default: res        = word;
    endcase
    return res;
  endfunction

  // Pipeline control
  logic     s1_vld_r, s1_vld_nxt;
  pic_in_t  s1_r;
  logic     out_vld_r, out_vld_nxt;
  pic_out_t out_r, out_nxt;
  logic     adv;

  // Register stores
  logic [31:0] pri_r [1:MAX_IRQ];
  logic [31:0] pri_nxt [1:MAX_IRQ];
  logic [31:0] en_r  [CTX_COUNT];
  logic [31:0] en_nxt  [CTX_COUNT];
  logic [31:0] th_r  [CTX_COUNT];
  logic [31:0] th_nxt  [CTX_COUNT];
  logic [31:0] cmp_r [CTX_COUNT];
  logic [31:0] cmp_nxt [CTX_COUNT];

  // Decode
  logic             is_wr;
  logic [1:0]       lane;
  logic             hit_pri, hit_en, hit_th;
  logic [SRC_W-1:0] pri_idx;
  logic [23:0]      en_off, th_off;
  logic [CTX_W-1:0] en_ctx, th_ctx;
  logic [31:0]      cmp_merged;
  logic [31:0]      pend;
  logic [MAX_IRQ:1] claim_hit;
  logic [SRC_W-1:0] claim_id;
  logic [31:0]      rd_word, rd_shift;

  assign adv       = !out_vld_r || out_ready;
  assign in_ready  = !s1_vld_r || adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = s1_vld_r;
      s1_vld_nxt  = in_valid;
    end else if (in_ready) begin
      s1_vld_nxt  = in_valid;
    end
  end

  // Address decode on the registered beat; priority beats enable beats threshold.
  assign is_wr   = (s1_r.cmd == CMD_WRITE);
  assign lane    = s1_r.address[1:0];
  assign hit_pri = is_wr && (s1_r.address >= PRIORITY_BASE)
                   && (s1_r.address < PRIORITY_END);
  assign hit_en  = !hit_pri && (s1_r.address >= ENABLE_BASE)
                   && (s1_r.address < ENABLE_END);
  assign hit_th  = !hit_pri && !hit_en && (s1_r.address >= THRESHOLD_BASE)
                   && (s1_r.address < THRESHOLD_END);
  assign pri_idx = s1_r.address[SRC_W+1:2];
  assign en_off  = s1_r.address - ENABLE_BASE;
  assign th_off  = s1_r.address - THRESHOLD_BASE;
  assign en_ctx  = en_off[ENABLE_SHIFT +: CTX_W];
  assign th_ctx  = th_off[THRESHOLD_SHIFT +: CTX_W];
  assign cmp_merged = merge_byte(cmp_r[th_ctx], lane, s1_r.write_data);

  // Claim scan: lowest pending, enabled source above the context threshold.
  assign pend = en_r[th_ctx] & s1_r.irq_lines;

  always_comb begin
    for (int s = 1; s <= MAX_IRQ; s++) begin
      claim_hit[SRC_W'(s)] = pend[SRC_W'(s)] && (pri_r[SRC_W'(s)] > th_r[th_ctx]);
    end
  end

  always_comb begin
    claim_id = '0;
    for (int s = MAX_IRQ; s >= 1; s--) begin
      if (claim_hit[SRC_W'(s)]) begin
        claim_id = SRC_W'(s);
      end
    end
  end

  // Store updates, only when the beat moves to the result register.
  always_comb begin
    pri_nxt = pri_r;
    en_nxt  = en_r;
    th_nxt  = th_r;
    cmp_nxt = cmp_r;
    if (s1_vld_r && adv && is_wr) begin
      if (hit_pri) begin
        if (pri_idx != '0) begin
          pri_nxt[pri_idx] = merge_byte(pri_r[pri_idx], lane, s1_r.write_data);
        end
      end else if (hit_en) begin
        en_nxt[en_ctx] = merge_byte(en_r[en_ctx], lane, s1_r.write_data);
      end else if (hit_th) begin
        if (!s1_r.address[2]) begin
          th_nxt[th_ctx] = merge_byte(th_r[th_ctx], lane, s1_r.write_data);
        end else begin
          cmp_nxt[th_ctx] = cmp_merged;
        end
      end
    end
  end

  // Result formation
  always_comb begin
    rd_word = '0;
    if (hit_en) begin
      rd_word = en_r[en_ctx];
    end else if (hit_th) begin
      rd_word = s1_r.address[2] ? {{(32-SRC_W){1'b0}}, claim_id} : th_r[th_ctx];
    end
  end

  assign rd_shift = rd_word >> {lane, 3'b000};

  always_comb begin
    out_nxt            = out_r;
    if (adv) begin
      out_nxt.read_data  = is_wr ? 8'h00 : rd_shift[7:0];
      out_nxt.addr_error = !(hit_pri || hit_en || hit_th);
      out_nxt.ack_valid  = 1'b0;
      out_nxt.ack_source = '0;
      // Completion acks only on a lane 0 write that leaves a valid source id.
      if (is_wr && hit_th && s1_r.address[2] && (lane == 2'd0)
          && (cmp_merged >= 32'd1) && (cmp_merged <= 32'(MAX_IRQ))) begin
        out_nxt.ack_valid  = 1'b1;
        out_nxt.ack_source = cmp_merged[SRC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pri_r     <= '{default: '0};
      en_r      <= '{default: '0};
      th_r      <= '{default: '0};
      cmp_r     <= '{default: '0};
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      pri_r     <= pri_nxt;
      en_r      <= en_nxt;
      th_r      <= th_nxt;
      cmp_r     <= cmp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    out_r <= out_nxt;
  end

  // Assertions
  a_ack_src_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.ack_valid |-> out_r.ack_source != '0)
    else $error("ack with source zero");

  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.addr_error |-> !out_r.ack_valid && out_r.read_data == 8'h00)
    else $error("error beat carries data or ack");

  a_ack_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.ack_valid |-> out_r.read_data == 8'h00)
    else $error("ack beat carries read data");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !adv |=> s1_vld_r && $stable(s1_r))
    else $error("input stage lost a beat while stalled");

endmodule
